/* design/rcfp_pkg.sv */
// Shared types and constants for the RC channel frame parser.
`default_nettype none

package rcfp_pkg;

  // Frame layout of a packed RC channels frame.
  localparam int NUM_CHANNELS    = 16;
  localparam int CHANNEL_BITS    = 11;
  localparam int MIN_FRAME_BYTES = 5;
  localparam int PAYLOAD_OFFSET  = 3;
  localparam int PAYLOAD_END     = PAYLOAD_OFFSET + (NUM_CHANNELS * CHANNEL_BITS) / 8;

  // Widths of the unpacking datapath.
  localparam int CHAN_IDX_W = 4;
  localparam int POS_W      = 5;
  localparam int ACC_W      = CHANNEL_BITS - 1 + 8;
  localparam int NBITS_W    = 5;

  // Frames that may be decoded but not yet fully unpacked.
  localparam int MAX_PENDING = 2;

  // Frame length as seen by the unpacker, saturated: it only reads offsets below 31.
  localparam logic [POS_W-1:0] MAX_LEN = '1;

  // One decoded frame handed from the front to the unpacker.
  typedef struct packed {
    logic             bank;
    logic [POS_W-1:0] len;
  } job_t;

  // Frame store read request from the unpacker.
  typedef struct packed {
    logic             en;
    logic             bank;
    logic [POS_W-1:0] pos;
  } rd_req_t;

endpackage

`default_nettype wire

/* design/rcfp_byte_if.sv */
// Byte stream channel: one received byte and its microsecond time per transaction.
`default_nettype none

interface rcfp_byte_if;
  logic        valid;
  logic        ready;
  logic [7:0]  rx_byte;
  logic [31:0] time_us;

  modport source (output valid, output rx_byte, output time_us, input ready);
  modport sink (input valid, input rx_byte, input time_us, output ready);
endinterface

`default_nettype wire

/* design/rcfp_chan_if.sv */
// Channel result stream: one unpacked RC channel value per transaction.
`default_nettype none

interface rcfp_chan_if;
  logic        valid;
  logic        ready;
  logic [3:0]  channel_index;
  logic [10:0] channel_value;
  logic        last_channel;

  modport source (output valid, output channel_index, output channel_value,
                  output last_channel, input ready);
  modport sink (input valid, input channel_index, input channel_value,
                input last_channel, output ready);
endinterface

`default_nettype wire

/* design/rcfp_front.sv */
// Byte intake: gap detection, double-banked frame store and frame recognition.
`default_nettype none

module rcfp_front #(
  parameter int STORE_BYTES = 64
) (
  input  wire logic            clk,
  input  wire logic            rst,
  rcfp_byte_if.sink            rx,
  input  wire logic [30:0]     gap_threshold_us,
  input  wire logic [7:0]      wanted_frame_type,
  output logic                 push,
  output rcfp_pkg::job_t       job,
  input  wire logic            release_job,
  input  wire rcfp_pkg::rd_req_t rd_req,
  output logic [7:0]           rd_data
);
  import rcfp_pkg::*;

  localparam int AW = $clog2(STORE_BYTES);
  localparam int CW = $clog2(STORE_BYTES + 1);

  logic [7:0]    store [2**(AW+1)];
  logic [CW-1:0] byte_count;
  logic [CW-1:0] cnt_base;
  logic [CW-1:0] cnt_new;
  logic [31:0]   last_time;
  logic [31:0]   diff;
  logic          gap;
  logic          write_ok;
  logic [7:0]    hdr_len;
  logic [7:0]    hdr_type;
  logic [7:0]    len_new;
  logic [7:0]    type_new;
  logic          wbank;
  logic [1:0]    pending;
  logic          accept;
  logic          frame_done;

  // New bytes are refused while both store banks hold frames not yet unpacked.
  assign rx.ready = (pending != 2'(MAX_PENDING));
  assign accept   = rx.valid && rx.ready;

  // A positive wrapped gap above the threshold starts a new frame.
  assign diff     = rx.time_us - last_time;
  assign gap      = !diff[31] && (diff[30:0] > gap_threshold_us);
  assign cnt_base = gap ? '0 : byte_count;
  assign write_ok = (cnt_base < CW'(STORE_BYTES));
  assign cnt_new  = write_ok ? cnt_base + CW'(1) : cnt_base;

  // Header bytes as they stand after this byte is stored.
  assign len_new  = (write_ok && cnt_base == CW'(1)) ? rx.rx_byte : hdr_len;
  assign type_new = (write_ok && cnt_base == CW'(2)) ? rx.rx_byte : hdr_type;

  // Frame recognition on the length and type bytes.
  assign frame_done = accept && (cnt_new >= CW'(MIN_FRAME_BYTES)) &&
                      (10'(cnt_new) == 10'(len_new) + 10'd2) &&
                      (type_new == wanted_frame_type);

  assign push     = frame_done;
  assign job.bank = wbank;
  assign job.len  = (cnt_new > CW'(MAX_LEN)) ? MAX_LEN : POS_W'(cnt_new);

  // Control state: fill count, byte time, bank select and frames in flight.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      last_time  <= '0;
      wbank      <= 1'b0;
      pending    <= '0;
    end else begin
      if (accept) begin
        last_time  <= rx.time_us;
        byte_count <= frame_done ? '0 : cnt_new;
      end
      if (frame_done) begin
        wbank <= ~wbank;
      end
      unique case ({push, release_job})
        2'b10:   pending <= pending + 2'd1;
        2'b01:   pending <= pending - 2'd1;
        default: pending <= pending;
      endcase
    end
  end

  // Header copies so frame checks need no store read.
  always_ff @(posedge clk) begin
    if (accept) begin
      hdr_len  <= len_new;
      hdr_type <= type_new;
    end
  end

  // Frame store: one write port for intake, one registered read port for the unpacker.
  always_ff @(posedge clk) begin
    if (accept && write_ok) begin
      store[{wbank, cnt_base[AW-1:0]}] <= rx.rx_byte;
    end
    if (rd_req.en) begin
      rd_data <= store[{rd_req.bank, AW'(rd_req.pos)}];
    end
  end

`ifndef SYNTH
  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= 2'(MAX_PENDING))
    else $error("more frames in flight than store banks");

  a_push_counts: assert property (@(posedge clk) disable iff (rst)
    push |=> pending != '0)
    else $error("decoded frame not counted as in flight");
`endif

endmodule

`default_nettype wire

/* design/rcfp_job_fifo.sv */
// Short queue of decoded frames between intake and unpacker.
`default_nettype none

module rcfp_job_fifo (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire rcfp_pkg::job_t push_job,
  input  wire logic           pop,
  output rcfp_pkg::job_t      head,
  output logic                head_valid
);
  import rcfp_pkg::*;

  localparam int PW = $clog2(MAX_PENDING);

  job_t          entries [MAX_PENDING];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;

  assign head       = entries[rd_ptr];
  assign head_valid = (count != '0);

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + (PW+1)'(1);
        2'b01:   count <= count - (PW+1)'(1);
        default: count <= count;
      endcase
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

`default_nettype wire

/* design/rcfp_back.sv */
// Unpacker: reads payload bytes one at a time and emits 11-bit channel values.
`default_nettype none

module rcfp_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire rcfp_pkg::job_t head,
  input  wire logic           head_valid,
  output logic                pop,
  output rcfp_pkg::rd_req_t   rd_req,
  input  wire logic [7:0]     rd_data,
  output logic                release_job,
  rcfp_chan_if.source         chan
);
  import rcfp_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_LOAD,
    S_EMIT
  } state_t;

  state_t                state;
  logic                  bank;
  logic [POS_W-1:0]      len;
  logic [POS_W-1:0]      pos;
  logic [ACC_W-1:0]      acc;
  logic [NBITS_W-1:0]    nbits;
  logic [CHAN_IDX_W-1:0] ch;
  logic                  out_valid;
  logic [CHAN_IDX_W-1:0] out_index;
  logic [10:0]           out_value;
  logic                  out_last;
  logic                  slot_free;
  logic                  emit;
  logic [7:0]            byte_v;

  assign chan.valid         = out_valid;
  assign chan.channel_index = out_index;
  assign chan.channel_value = out_value;
  assign chan.last_channel  = out_last;

  // The output register may be refilled when empty or being taken this cycle.
  assign slot_free   = !out_valid || chan.ready;
  assign emit        = (state == S_EMIT) && (nbits >= NBITS_W'(CHANNEL_BITS)) && slot_free;
  assign release_job = emit && (ch == CHAN_IDX_W'(NUM_CHANNELS - 1));
  assign pop         = (state == S_IDLE) && head_valid;

  assign rd_req.en   = (state == S_READ);
  assign rd_req.bank = bank;
  assign rd_req.pos  = pos;

  // Bytes beyond the received length read as zero.
  assign byte_v = (pos < len) ? rd_data : 8'd0;

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // A channel taken this cycle empties the register unless the next one replaces it.
      if (out_valid && chan.ready && !emit) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (head_valid) begin
            bank  <= head.bank;
            len   <= head.len;
            pos   <= POS_W'(PAYLOAD_OFFSET);
            acc   <= '0;
            nbits <= '0;
            ch    <= '0;
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          acc   <= acc | (ACC_W'(byte_v) << nbits);
          nbits <= nbits + NBITS_W'(8);
          pos   <= pos + POS_W'(1);
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (nbits < NBITS_W'(CHANNEL_BITS)) begin
            state <= S_READ;
          end else if (slot_free) begin
            out_valid <= 1'b1;
            out_index <= ch;
            out_value <= acc[CHANNEL_BITS-1:0];
            out_last  <= release_job;
            acc       <= acc >> CHANNEL_BITS;
            nbits     <= nbits - NBITS_W'(CHANNEL_BITS);
            ch        <= ch + CHAN_IDX_W'(1);
            if (release_job) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_frame_consumed: assert property (@(posedge clk) disable iff (rst)
    release_job |-> (nbits == NBITS_W'(CHANNEL_BITS)) && (pos == POS_W'(PAYLOAD_END)))
    else $error("frame finished with payload bits left over");

  a_acc_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> nbits <= NBITS_W'(ACC_W))
    else $error("bit accumulator overflow");
`endif

endmodule

`default_nettype wire

/* design/rc_channel_frame_parser.sv */
// Top level of the RC channel frame parser: configuration registers and unit wiring.
// With the unpacker idle, the first channel of a frame follows the byte that completes it
// through the job queue and two payload byte reads, each in a read and a load state.
// Throughput: one byte per cycle; byte intake stalls only while two decoded frames are not
// yet fully unpacked. The unpacker holds one frame at a time: it takes it, reads each of the
// 22 payload bytes in a read and a load state and emits each channel once the output is free.
// Reset: synchronous; registers return to 1000 us and type 22; the store is not cleared.
`default_nettype none

module rc_channel_frame_parser #(
  parameter int STORE_BYTES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  rcfp_byte_if.sink        rx,
  rcfp_chan_if.source      chan,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import rcfp_pkg::*;

  localparam logic REG_GAP  = 1'b0;
  localparam logic REG_TYPE = 1'b1;

  logic [30:0] gap_threshold_us;
  logic [7:0]  wanted_frame_type;
  logic        push;
  logic        pop;
  logic        head_valid;
  logic        release_job;
  logic [7:0]  rd_data;
  job_t        job;
  job_t        head;
  rd_req_t     rd_req;

  assign pready = 1'b1;

  // Configuration writes complete in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      gap_threshold_us  <= 31'd1000;
      wanted_frame_type <= 8'd22;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_GAP:  gap_threshold_us  <= pwdata[30:0];
        REG_TYPE: wanted_frame_type <= pwdata[7:0];
        default:  gap_threshold_us  <= gap_threshold_us;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (paddr[2])
      REG_GAP:  prdata = {1'b0, gap_threshold_us};
      REG_TYPE: prdata = {24'd0, wanted_frame_type};
      default:  prdata = '0;
    endcase
  end

  rcfp_front #(
    .STORE_BYTES(STORE_BYTES)
  ) u_front (
    .clk              (clk),
    .rst              (rst),
    .rx               (rx),
    .gap_threshold_us (gap_threshold_us),
    .wanted_frame_type(wanted_frame_type),
    .push             (push),
    .job              (job),
    .release_job      (release_job),
    .rd_req           (rd_req),
    .rd_data          (rd_data)
  );

  rcfp_job_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (job),
    .pop       (pop),
    .head      (head),
    .head_valid(head_valid)
  );

  rcfp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .rd_req     (rd_req),
    .rd_data    (rd_data),
    .release_job(release_job),
    .chan       (chan)
  );

endmodule

`default_nettype wire

/* tb/rcfp_tb_pkg.sv */
// Register map of the configuration port, shared by the testbench top and the checker.
`timescale 1ns / 100ps

package rcfp_tb_pkg;

  // Byte addresses of the two configuration registers.
  localparam logic [2:0] GAP_THRESHOLD_ADDR = 3'd0;
  localparam logic [2:0] FRAME_TYPE_ADDR    = 3'd4;

endpackage

/* tb/rcfp_channel_checker.sv */
// Checker that predicts the channel results from the byte stream and compares them.
`timescale 1ns / 100ps

module rcfp_channel_checker #(
  parameter int STORE_BYTES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  rcfp_byte_if             rx,
  rcfp_chan_if             chan,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic        pready,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output int unsigned      mismatch_count,
  output int unsigned      channels_pending
);
  import rcfp_pkg::*;
  import rcfp_tb_pkg::*;

  typedef struct packed {
    logic [CHAN_IDX_W-1:0]   index;
    logic [CHANNEL_BITS-1:0] value;
    logic                    last;
  } chan_result_t;

  // Shadow of the frame assembly state and the configuration registers.
  logic [7:0]   frame_bytes [STORE_BYTES];
  int unsigned  held_count = 0;
  logic [31:0]  prev_time  = '0;
  logic [30:0]  gap_limit  = 31'd1000;
  logic [7:0]   frame_type = 8'd22;
  chan_result_t expected_channels[$];

  // Bytes at or past the held count read as zero.
  function automatic logic [7:0] stored_at(input int unsigned pos);
    if (pos >= held_count || pos >= STORE_BYTES) return 8'h00;
    return frame_bytes[pos];
  endfunction

  // Append one byte to the frame and queue the 16 channels when it completes one.
  task automatic absorb_byte(input logic [7:0] b, input logic [31:0] t);
    logic [31:0]  elapsed;
    logic [23:0]  window;
    int unsigned  bitpos;
    int unsigned  pos;
    chan_result_t res;
    elapsed = t - prev_time;
    // A wrapped difference that reads as negative never opens a new frame.
    if (!elapsed[31] && elapsed > {1'b0, gap_limit}) held_count = 0;
    // A full store drops the byte, yet the time still moves on.
    if (held_count < STORE_BYTES) begin
      frame_bytes[held_count] = b;
      held_count++;
    end
    prev_time = t;
    if (held_count >= MIN_FRAME_BYTES && held_count == int'(frame_bytes[1]) + 2 &&
        frame_bytes[2] == frame_type) begin
      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
        bitpos = ch * CHANNEL_BITS;
        pos = PAYLOAD_OFFSET + bitpos / 8;
        window = {stored_at(pos + 2), stored_at(pos + 1), stored_at(pos)};
        res.index = ch[CHAN_IDX_W-1:0];
        res.value = window[bitpos % 8 +: CHANNEL_BITS];
        res.last = (ch == NUM_CHANNELS - 1);
        expected_channels = {expected_channels, res};
      end
      held_count = 0;
    end
  endtask

  // Follow register writes and byte transactions, then compare each channel transaction.
  always @(posedge clk) begin : watch
    chan_result_t want;
    int unsigned  errs;
    errs = 0;
    if (rst) begin
      held_count = 0;
      prev_time = '0;
      gap_limit = 31'd1000;
      frame_type = 8'd22;
      expected_channels.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          GAP_THRESHOLD_ADDR: gap_limit = pwdata[30:0];
          FRAME_TYPE_ADDR:    frame_type = pwdata[7:0];
          default: ;
        endcase
      end
      if (rx.valid && rx.ready) absorb_byte(rx.rx_byte, rx.time_us);
      if (chan.valid && chan.ready) begin
        if (expected_channels.size() == 0) begin
          $error("unexpected channel transaction: index %0d value %0d last %0d",
                 chan.channel_index, chan.channel_value, chan.last_channel);
          errs++;
        end else begin
          want = expected_channels.pop_front();
          if (chan.channel_index !== want.index) begin
            $error("channel_index: expected %0d, actual %0d", want.index, chan.channel_index);
            errs++;
          end
          if (chan.channel_value !== want.value) begin
            $error("channel_value: expected %0d, actual %0d", want.value, chan.channel_value);
            errs++;
          end
          if (chan.last_channel !== want.last) begin
            $error("last_channel: expected %0d, actual %0d", want.last, chan.last_channel);
            errs++;
          end
        end
      end
    end
    mismatch_count <= mismatch_count + errs;
    channels_pending <= expected_channels.size();
  end

endmodule

/* tb/tb_rc_channel_frame_parser.sv */
// Testbench top: clock, reset, byte and register stimulus, result back-pressure and verdict.
`timescale 1ns / 100ps

module tb_rc_channel_frame_parser;
  import rcfp_tb_pkg::*;

  localparam int          STORE_BYTES   = 64;
  localparam int unsigned CYCLE_LIMIT   = 300000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned TAIL_CYCLES   = 200;

  logic        clk     = 1'b0;
  logic        rst     = 1'b1;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  logic        sink_ready = 1'b0;
  int unsigned sink_hold  = 0;
  bit          sink_calm  = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned mismatch_count;
  int unsigned channels_pending;

  // Stimulus view of time and configuration.
  logic [31:0] now_us     = '0;
  logic [30:0] cur_gap_us = 31'd1000;
  logic [7:0]  cur_type   = 8'd22;
  bit          src_calm   = 1'b0;
  int unsigned bytes_sent = 0;

  rcfp_byte_if rx_bus ();
  rcfp_chan_if chan_bus ();

  assign chan_bus.ready = sink_ready;

  rc_channel_frame_parser #(.STORE_BYTES(STORE_BYTES)) dut (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx_bus),
    .chan    (chan_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  rcfp_channel_checker #(.STORE_BYTES(STORE_BYTES)) checker_i (
    .clk              (clk),
    .rst              (rst),
    .rx               (rx_bus),
    .chan             (chan_bus),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .pready           (pready),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .mismatch_count   (mismatch_count),
    .channels_pending (channels_pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("rc_channel_frame_parser regression: fail");
      $finish;
    end
  end

  // Result side: after each transaction a random stall may follow; some frames see no stall.
  always @(posedge clk) begin : result_sink
    int unsigned stall;
    if (rst) begin
      sink_ready <= 1'b0;
      sink_hold <= 0;
    end else if (sink_ready) begin
      if (chan_bus.valid) begin
        if (chan_bus.last_channel) sink_calm <= ($urandom_range(0, 2) == 0);
        stall = sink_calm ? 0 : $urandom_range(0, 9);
        if (stall != 0) begin
          sink_ready <= 1'b0;
          sink_hold <= stall - 1;
        end
      end
    end else if (sink_hold == 0) begin
      sink_ready <= 1'b1;
    end else begin
      sink_hold <= sink_hold - 1;
    end
  end

  // One byte transaction after a random idle gap.
  task automatic push_byte(input logic [7:0] b, input logic [31:0] t);
    int unsigned idle;
    idle = src_calm ? 0 : $urandom_range(0, 9);
    if (idle != 0) begin
      rx_bus.valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    rx_bus.valid <= 1'b1;
    rx_bus.rx_byte <= b;
    rx_bus.time_us <= t;
    do @(posedge clk); while (!rx_bus.ready);
    now_us = t;
    bytes_sent++;
  endtask

  // Time of a byte inside a frame: never beyond the current threshold.
  function automatic logic [31:0] frame_time();
    int unsigned span;
    span = (cur_gap_us < 3000) ? cur_gap_us : 3000;
    return now_us + $urandom_range(0, span);
  endfunction

  // Time of a byte that opens a frame; with the largest threshold no gap is possible.
  function automatic logic [31:0] gap_time();
    if (cur_gap_us > 31'h7FFF_0000) return now_us + $urandom_range(0, 100);
    return now_us + cur_gap_us + 1 + $urandom_range(0, 2000);
  endfunction

  // A frame of the given length byte and type, cut after keep bytes.
  task automatic send_frame(input int unsigned len, input logic [7:0] tbyte,
                            input int unsigned keep);
    int unsigned style;
    logic [7:0]  b;
    style = $urandom_range(0, 5);
    if (keep > len + 2) keep = len + 2;
    for (int unsigned k = 0; k < keep; k++) begin
      if (k == 1) b = len[7:0];
      else if (k == 2) b = tbyte;
      else if (k > 2 && style == 0) b = 8'hFF;
      else if (k > 2 && style == 1) b = 8'h00;
      else b = 8'($urandom);
      push_byte(b, (k == 0) ? gap_time() : frame_time());
    end
  endtask

  // Mostly well-formed frames with random content, plus noise and cut frames.
  task automatic run_random(input int unsigned budget);
    int unsigned stop;
    int unsigned roll;
    int unsigned len;
    stop = bytes_sent + budget;
    while (bytes_sent < stop) begin
      src_calm = ($urandom_range(0, 3) == 0);
      roll = $urandom_range(0, 99);
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(3, STORE_BYTES - 2) : 24;
      if (roll < 65)
        send_frame(len, ($urandom_range(0, 9) == 0) ? 8'($urandom) : cur_type, len + 2);
      else if (roll < 80)
        repeat ($urandom_range(1, 3)) push_byte(8'($urandom), $urandom);
      else
        send_frame(len, cur_type, $urandom_range(1, len + 1));
    end
  endtask

  // Back-to-back valid frames only, for a threshold that never opens a frame.
  task automatic run_frames(input int unsigned budget);
    int unsigned stop;
    int unsigned len;
    stop = bytes_sent + budget;
    while (bytes_sent < stop) begin
      src_calm = ($urandom_range(0, 3) == 0);
      len = ($urandom_range(0, 2) == 0) ? $urandom_range(3, STORE_BYTES - 2) : 24;
      send_frame(len, cur_type, len + 2);
    end
  endtask

  // APB write: setup phase, access phase, then idle.
  task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    if (addr == GAP_THRESHOLD_ADDR) cur_gap_us = value[30:0];
    else if (addr == FRAME_TYPE_ADDR) cur_type = value[7:0];
  endtask

  // Wait until every predicted channel has arrived and the front end has drained.
  task automatic settle();
    rx_bus.valid <= 1'b0;
    do @(posedge clk); while (channels_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    rx_bus.valid <= 1'b0;
    rx_bus.rx_byte <= '0;
    rx_bus.time_us <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Short frame opened by the largest positive gap; channels past the data read zero.
    push_byte(8'hC8, 32'h7FFF_FFFF);
    push_byte(8'd3, now_us + 1);
    push_byte(cur_type, now_us + 1);
    push_byte(8'hFF, now_us + 1);
    push_byte(8'hFF, now_us + 1);

    // Negative time differences must not restart the frame.
    push_byte(8'hC8, now_us + 5000);
    push_byte(8'd4, now_us + 32'h8000_0000);
    push_byte(cur_type, now_us + 32'hFFFF_FFFF);
    push_byte(8'h00, now_us);
    push_byte(8'h00, now_us);
    push_byte(8'hFF, now_us);

    // Wrong type gives nothing; a gap of exactly the threshold keeps the frame open.
    push_byte(8'hC8, now_us + 1001);
    push_byte(8'd3, now_us + 2);
    push_byte(cur_type + 8'd1, now_us + 3);
    push_byte(8'hAA, now_us);
    push_byte(8'h55, now_us);
    push_byte(8'h5A, now_us + 1000);

    // One past the threshold starts a fresh, valid frame.
    push_byte(8'hC8, now_us + 1001);
    push_byte(8'd3, now_us);
    push_byte(cur_type, now_us);
    push_byte(8'h00, now_us);
    push_byte(8'h80, now_us);

    run_random(25);
    settle();

    // Zero threshold: any forward step in time opens a frame.
    reg_write(GAP_THRESHOLD_ADDR, 32'd0);
    reg_write(FRAME_TYPE_ADDR, 32'd255);
    run_random(10);
    settle();

    // Largest threshold: frames are only delimited by decoding.
    reg_write(GAP_THRESHOLD_ADDR, 32'h7FFF_FFFF);
    reg_write(FRAME_TYPE_ADDR, 32'd0);
    run_frames(10);
    settle();

    // Random settings; overfill the store so the last bytes are dropped.
    reg_write(GAP_THRESHOLD_ADDR, $urandom_range(1, 200000));
    reg_write(FRAME_TYPE_ADDR, $urandom_range(0, 255));
    push_byte(8'($urandom), gap_time());
    push_byte(8'd200, frame_time());
    repeat (STORE_BYTES) push_byte(8'($urandom), frame_time());
    settle();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && channels_pending == 0) begin
      $display("rc_channel_frame_parser regression: pass");
    end else begin
      $display("rc_channel_frame_parser regression: fail");
    end
    $finish;
  end

endmodule

/* files.f */
design/rcfp_pkg.sv
design/rcfp_byte_if.sv
design/rcfp_chan_if.sv
design/rcfp_front.sv
design/rcfp_job_fifo.sv
design/rcfp_back.sv
design/rc_channel_frame_parser.sv
tb/rcfp_tb_pkg.sv
tb/rcfp_channel_checker.sv
tb/tb_rc_channel_frame_parser.sv
